// ----- rtl/ict_pkg.sv -----
// shared constants and types of the 4x4 integer core transform
package ict_pkg;

    // default values of the top level parameters
    localparam int PIXEL_BITS_DEF      = 8;
    localparam int SCALE_FRAC_BITS_DEF = 16;

    // fixed field widths
    localparam int SCALE_W  = 16;
    localparam int COEF_W   = 11;
    localparam int COEF_MAX = 1023;
    localparam int COEF_MIN_MAG = 1024;

    // register map, word index taken from paddr[3:2]
    localparam logic [1:0] REG_SCALE_EE  = 2'd0;
    localparam logic [1:0] REG_SCALE_MIX = 2'd1;
    localparam logic [1:0] REG_SCALE_OO  = 2'd2;

    // scale reset values, q16
    localparam logic [SCALE_W-1:0] SCALE_EE_RST  = 16'd16384;
    localparam logic [SCALE_W-1:0] SCALE_MIX_RST = 16'd10361;
    localparam logic [SCALE_W-1:0] SCALE_OO_RST  = 16'd1638;

    // integer core matrix
    localparam logic signed [2:0] CORE_MAT [0:3][0:3] = '{
        '{ 3'sd1,  3'sd1,  3'sd1,  3'sd1},
        '{ 3'sd2,  3'sd1, -3'sd1, -3'sd2},
        '{ 3'sd1, -3'sd1, -3'sd1,  3'sd1},
        '{ 3'sd1, -3'sd2,  3'sd2, -3'sd1}
    };

    typedef enum logic [1:0] {
        S_COLLECT,
        S_ACCUM,
        S_SCALE
    } t_state;

endpackage

// ----- rtl/integer_core_transform_4x4_top.sv -----
// top level of the 4x4 integer core transform with position post-scaling
//
// the block takes a 4x4 luma block one row of four samples per request and
// returns four rows of scaled coefficients W = C*X*C^T. each input row is
// run through the horizontal transform as it arrives and rows zero to two
// go into a three-entry row memory (one write port, one registered read
// port); the fourth row seeds a bank of sixteen accumulators directly. the
// vertical pass then reads the three stored rows back, one a cycle, and
// adds them into the accumulators. a single shared multiplier scales one
// coefficient a cycle, followed by a truncate-toward-zero and saturate
// stage, and holds while a finished row waits for a full output register;
// each finished row goes to an output register, so a row may wait there
// while the next one is formed. the fourth row starts the vertical pass
// and then the scale sweep; no input request is taken during that pass.
// scales are written through an apb-style port (word 0 even-even, 1 mixed,
// 2 odd-odd, q format with SCALE_FRAC_BITS fraction bits) and should only
// change while idle.
module integer_core_transform_4x4_top
    import ict_pkg::*;
#(
    parameter int PIXEL_BITS      = PIXEL_BITS_DEF,
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    // input rows
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [PIXEL_BITS-1:0]    i_sample_0,
    input  logic [PIXEL_BITS-1:0]    i_sample_1,
    input  logic [PIXEL_BITS-1:0]    i_sample_2,
    input  logic [PIXEL_BITS-1:0]    i_sample_3,

    // coefficient rows
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [COEF_W-1:0] o_coef_0,
    output logic signed [COEF_W-1:0] o_coef_1,
    output logic signed [COEF_W-1:0] o_coef_2,
    output logic signed [COEF_W-1:0] o_coef_3,
    output logic [1:0]               o_coef_row,
    output logic                     o_block_last,

    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    // horizontal result, full coefficient and magnitude, product widths
    localparam int H_W = PIXEL_BITS + 4;
    localparam int W_W = PIXEL_BITS + 7;
    localparam int M_W = W_W - 1;
    localparam int P_W = M_W + SCALE_W;

    // one constant-coefficient term: the core matrix holds only +-1 and +-2
    function automatic logic signed [W_W-1:0] f_term(
        input logic signed [2:0]     k,
        input logic signed [H_W-1:0] h
    );
        logic signed [W_W-1:0] e;
        logic signed [W_W-1:0] t;
        e = {{(W_W-H_W){h[H_W-1]}}, h};
        case (k)
            3'sd1:   t = e;
            -3'sd1:  t = -e;
            3'sd2:   t = e <<< 1;
            -3'sd2:  t = -(e <<< 1);
            default: t = '0;
        endcase
        return t;
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [SCALE_W-1:0] r_scale_ee;
    logic [SCALE_W-1:0] r_scale_mix;
    logic [SCALE_W-1:0] r_scale_oo;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_ee  <= SCALE_EE_RST;
            r_scale_mix <= SCALE_MIX_RST;
            r_scale_oo  <= SCALE_OO_RST;
        end else if (cfg_wr) begin
            // word index three is not mapped and is dropped
            unique case (paddr[3:2])
                REG_SCALE_EE:  r_scale_ee  <= pwdata[SCALE_W-1:0];
                REG_SCALE_MIX: r_scale_mix <= pwdata[SCALE_W-1:0];
                REG_SCALE_OO:  r_scale_oo  <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SCALE_EE:  prdata = {{(32-SCALE_W){1'b0}}, r_scale_ee};
            REG_SCALE_MIX: prdata = {{(32-SCALE_W){1'b0}}, r_scale_mix};
            REG_SCALE_OO:  prdata = {{(32-SCALE_W){1'b0}}, r_scale_oo};
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    t_state       r_state;
    t_state       n_state;
    logic [1:0]   r_rows;        // rows of the current block taken so far
    logic [1:0]   r_k;           // next stored row to read, three when done
    logic         r_rd_vld;      // read data of row r_rd_k is in r_rd_data
    logic [1:0]   r_rd_k;
    logic [3:0]   r_idx;         // next coefficient to scale, row-major
    logic         r_issue_done;  // all sixteen coefficients issued
    logic         r_p_vld;       // product stage holds a coefficient
    logic [3:0]   r_p_idx;
    logic         r_p_neg;
    logic [P_W-1:0] r_prod;
    logic         r_out_vld;

    logic in_acc;
    logic last_row_acc;
    logic rd_issue;
    logic sc_issue;
    logic stall;
    logic row_done;

    assign o_in_ready   = (r_state == S_COLLECT);
    assign in_acc       = i_in_valid & o_in_ready;
    assign last_row_acc = in_acc && (r_rows == 2'd3);
    assign rd_issue     = (r_state == S_ACCUM) && (r_k != 2'd3);

    // a finished row can only move into the output register once it is free
    assign stall    = r_p_vld && (r_p_idx[1:0] == 2'd3) && r_out_vld && !i_out_ready;
    assign sc_issue = (r_state == S_SCALE) && !r_issue_done && !stall;
    assign row_done = r_p_vld && (r_p_idx[1:0] == 2'd3) && !stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_COLLECT: begin
                if (last_row_acc) n_state = S_ACCUM;
            end
            S_ACCUM: begin
                if (r_rd_vld && (r_rd_k == 2'd2)) n_state = S_SCALE;
            end
            S_SCALE: begin
                if (row_done && (r_p_idx == 4'hf)) n_state = S_COLLECT;
            end
            default: n_state = S_COLLECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows       <= '0;
            r_k          <= 2'd3;
            r_rd_vld     <= 1'b0;
            r_idx        <= '0;
            r_issue_done <= 1'b1;
            r_p_vld      <= 1'b0;
        end else begin
            if (in_acc) r_rows <= r_rows + 2'd1;

            // start of the vertical pass and of the scale sweep
            if (last_row_acc) begin
                r_k          <= '0;
                r_idx        <= '0;
                r_issue_done <= 1'b0;
            end else if (rd_issue) begin
                r_k <= r_k + 2'd1;
            end
            r_rd_vld <= rd_issue;

            if (sc_issue) begin
                r_idx <= r_idx + 4'd1;
                if (r_idx == 4'hf) r_issue_done <= 1'b1;
            end
            if (!stall) r_p_vld <= sc_issue;
        end
    end

    // ------------------------------------------------------------------
    // horizontal transform of the incoming row
    // ------------------------------------------------------------------
    logic signed [H_W-1:0] x [0:3];
    logic signed [H_W-1:0] h_in [0:3];

    assign x[0] = $signed({4'b0000, i_sample_0});
    assign x[1] = $signed({4'b0000, i_sample_1});
    assign x[2] = $signed({4'b0000, i_sample_2});
    assign x[3] = $signed({4'b0000, i_sample_3});

    assign h_in[0] = x[0] + x[1] + x[2] + x[3];
    assign h_in[1] = (x[0] <<< 1) + x[1] - x[2] - (x[3] <<< 1);
    assign h_in[2] = x[0] - x[1] - x[2] + x[3];
    assign h_in[3] = x[0] - (x[1] <<< 1) + (x[2] <<< 1) - x[3];

    // ------------------------------------------------------------------
    // row memory, rows zero to two of the horizontal result
    // ------------------------------------------------------------------
    logic [4*H_W-1:0] r_mem [0:2];
    logic [4*H_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (in_acc && (r_rows != 2'd3)) begin
            r_mem[r_rows] <= {h_in[3], h_in[2], h_in[1], h_in[0]};
        end
        if (rd_issue) begin
            r_rd_data <= r_mem[r_k];
            r_rd_k    <= r_k;
        end
    end

    // ------------------------------------------------------------------
    // vertical pass: W[r][c] += C[r][k] * H[k][c]
    // ------------------------------------------------------------------
    logic signed [W_W-1:0] r_acc [0:3][0:3];
    logic signed [W_W-1:0] n_acc [0:3][0:3];
    logic signed [H_W-1:0] h_sel [0:3];
    logic [1:0]            k_sel;

    always_comb begin
        // the fourth row seeds the bank, stored rows add in afterward
        k_sel = last_row_acc ? 2'd3 : r_rd_k;
        for (int c = 0; c < 4; c++) begin
            h_sel[c] = last_row_acc ? h_in[c] : $signed(r_rd_data[c*H_W +: H_W]);
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                n_acc[r][c] = (last_row_acc ? '0 : r_acc[r][c])
                            + f_term(CORE_MAT[r][k_sel], h_sel[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (last_row_acc || r_rd_vld) begin
            r_acc <= n_acc;
        end
    end

    // ------------------------------------------------------------------
    // scale: one multiply a cycle unless held by a full output register, then truncate and saturate
    // ------------------------------------------------------------------
    logic signed [W_W-1:0] w_sel;
    logic signed [W_W-1:0] w_abs;
    logic [SCALE_W-1:0]    scl_sel;

    always_comb begin
        w_sel = r_acc[r_idx[3:2]][r_idx[1:0]];
        w_abs = w_sel[W_W-1] ? -w_sel : w_sel;
        case ({r_idx[2], r_idx[0]})
            2'b00:   scl_sel = r_scale_ee;
            2'b11:   scl_sel = r_scale_oo;
            default: scl_sel = r_scale_mix;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (sc_issue) begin
            r_prod  <= P_W'(w_abs[M_W-1:0]) * P_W'(scl_sel);
            r_p_neg <= w_sel[W_W-1];
            r_p_idx <= r_idx;
        end
    end

    logic [P_W-1:0]          q;
    logic [COEF_W:0]         q_neg;
    logic signed [COEF_W-1:0] sat;

    always_comb begin
        q     = r_prod >> SCALE_FRAC_BITS;
        q_neg = -q[COEF_W:0];
        if (!r_p_neg) begin
            sat = (q > P_W'(COEF_MAX)) ? COEF_W'(COEF_MAX) : $signed(q[COEF_W-1:0]);
        end else begin
            sat = (q > P_W'(COEF_MIN_MAG)) ? $signed(COEF_W'(COEF_MIN_MAG))
                                            : $signed(q_neg[COEF_W-1:0]);
        end
    end

    // ------------------------------------------------------------------
    // row assembly and output register
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0] r_stage [0:2];

    always_ff @(posedge i_clk) begin
        if (r_p_vld && (r_p_idx[1:0] != 2'd3)) begin
            r_stage[r_p_idx[1:0]] <= sat;
        end
        if (row_done) begin
            o_coef_0     <= r_stage[0];
            o_coef_1     <= r_stage[1];
            o_coef_2     <= r_stage[2];
            o_coef_3     <= sat;
            o_coef_row   <= r_p_idx[3:2];
            o_block_last <= (r_p_idx[3:2] == 2'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (row_done) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out_valid = r_out_vld;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_block_last == (o_coef_row == 2'd3)))
        else $error("block_last does not match coefficient row");

    a_no_input_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_vld || r_rd_vld) |-> !o_in_ready)
        else $error("input taken while a block is in the transform pass");

    a_pass_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_row_acc |=> (r_state == S_ACCUM) && (r_k == 2'd0))
        else $error("fourth row did not start the vertical pass");

    // a row leaves only once the sweep has moved on to the start of the next row
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        row_done |-> (r_issue_done || (r_idx[1:0] == 2'd0)))
        else $error("scale sweep out of order");

endmodule
